// ===== hdl/atx_pkg.sv =====
// Package for the ANSI text terminal: cell layout, controller states,
// parser modes and the byte codes that the escape parser recognizes.
// No dependencies.
`default_nettype none

package atx_pkg;

    // One screen cell as stored in the screen memory
    typedef struct packed {
        logic [2:0] bg;
        logic [2:0] fg;
        logic [7:0] ch;
    } cell_t;

    localparam int CELL_W = 14;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_COLOR,
        ST_FINISH
    } state_t;

    // Byte parser modes
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } mode_t;

    // Control bytes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // Escape and CSI bytes
    localparam logic [7:0] CH_SAVE   = 8'h37;  // '7'
    localparam logic [7:0] CH_REST   = 8'h38;  // '8'
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_DIG0   = 8'h30;  // '0'
    localparam logic [7:0] CH_DIG9   = 8'h39;  // '9'
    localparam logic [7:0] CH_SGR    = 8'h6D;  // 'm'
    localparam logic [7:0] CH_CUF    = 8'h43;  // 'C'
    localparam logic [7:0] CH_CUB    = 8'h44;  // 'D'
    localparam logic [7:0] CH_CUP    = 8'h48;  // 'H'
    localparam logic [7:0] CH_HVP    = 8'h66;  // 'f'
    localparam logic [7:0] CH_ED     = 8'h4A;  // 'J'

    // Color parameter values
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] SGR_FG_DEF = 8'd39;
    localparam logic [7:0] SGR_BG_DEF = 8'd49;

    localparam logic [2:0] COLOR_WHITE = 3'd7;
    localparam logic [2:0] COLOR_BLACK = 3'd0;

    localparam logic [7:0] ED_ALL  = 8'd2;
    localparam logic [7:0] NUM_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== hdl/ansi_text_terminal.sv =====
// ANSI text terminal top level: byte parser, cursor control and screen store.
// Depends on atx_pkg and atx_ram.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  func, data_byte, cell_addr
//   output   out        out_valid/out_ready  cell_char, cell_fg, cell_bg,
//                                            pos_row, pos_col
//
// An ordinary write decodes and writes the cell, then loads the result; a read
// reads the memory, then loads the result. A color sequence (m) steps through
// each filled parameter slot first. A scroll walks the screen memory once
// through its single read and write ports, copying ROWS*COLUMNS-COLUMNS cells
// one row up, then filling COLUMNS cells. Erase display (2J) fills ROWS*COLUMNS
// cells. After reset the screen memory is filled while in_ready stays low. A
// result waiting on out_ready does not block the next input transaction; only
// the following result waits for the output register.
`default_nettype none

module ansi_text_terminal #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int PARAM_SLOTS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    input  wire logic [10:0] cell_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       cell_char,
    output logic [2:0]       cell_fg,
    output logic [2:0]       cell_bg,
    output logic [4:0]       pos_row,
    output logic [6:0]       pos_col
);

    import atx_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CLW   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
    localparam int SW    = (PARAM_SLOTS > 2) ? $clog2(PARAM_SLOTS) : 1;
    localparam int XW    = ((AW > 11) ? AW : 11) + 1;
    localparam int LIM   = CELLS - COLUMNS;

    // Control registers
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CLW-1:0]     col_reg, col_next;
    logic [RW-1:0]      srow_reg, srow_next;
    logic [CLW-1:0]     scol_reg, scol_next;
    logic [2:0]         fg_reg, fg_next;
    logic [2:0]         bg_reg, bg_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [SW-1:0]      j_reg, j_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               is_read_reg, is_read_next;
    logic               in_range_reg, in_range_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers
    logic [7:0]         acc_reg, acc_next;
    logic [7:0]         nums_reg [PARAM_SLOTS];
    logic [7:0]         nums_next [PARAM_SLOTS];
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    cell_t              out_cell_reg, out_cell_next;
    logic [RW-1:0]      out_row_reg, out_row_next;
    logic [CLW-1:0]     out_col_reg, out_col_next;

    // Memory ports
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    cell_t              ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    // Decode helpers
    logic               back_ok;
    logic [RW-1:0]      back_row;
    logic [CLW-1:0]     back_col;
    logic               use_back;
    logic [RW-1:0]      a_row;
    logic [CLW-1:0]     a_col;
    logic [AW-1:0]      cur_addr;
    logic [11:0]        dig_sum;
    logic [7:0]         n0;
    logic [8:0]         col_sum;
    logic [7:0]         p;
    logic               out_free;
    cell_t              blank;

    atx_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Step back one cell, wrapping to the end of the previous row
    always_comb
    begin
        back_ok  = 1'b1;
        back_row = row_reg;
        back_col = col_reg;
        if (col_reg != '0)
        begin
            back_col = col_reg - CLW'(1);
        end
        else if (row_reg != '0)
        begin
            back_row = row_reg - RW'(1);
            back_col = CLW'(COLUMNS - 1);
        end
        else
        begin
            back_ok = 1'b0;
        end
    end

    // Cell address of the cursor, or of the cell behind it for erase
    assign use_back = (mode_reg == MODE_NORMAL) && (data_byte == CH_DEL);
    assign a_row    = use_back ? back_row : row_reg;
    assign a_col    = use_back ? back_col : col_reg;
    assign cur_addr = AW'(AW'(a_row) * AW'(COLUMNS)) + AW'(a_col);

    assign blank    = '{bg: bg_reg, fg: fg_reg, ch: CH_SPACE};
    assign dig_sum  = 12'(acc_reg) * 12'd10 + 12'(data_byte - CH_DIG0);
    assign n0       = (nums_reg[0] == 8'd0) ? 8'd1 : nums_reg[0];
    assign col_sum  = 9'(col_reg) + 9'(n0);
    assign p        = nums_reg[j_reg];
    assign out_free = !out_valid_reg || out_ready;

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        slot_next      = slot_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        is_read_next   = is_read_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        nums_next      = nums_reg;
        wr_addr_next   = wr_addr_reg;
        out_cell_next  = out_cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cur_addr;
        ram_wr_data    = '{bg: bg_reg, fg: fg_reg, ch: data_byte};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = AW'(cell_addr);

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_FILL:
            begin
                // Blank one cell per cycle up to the end of the screen
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg;
                ram_wr_data = blank;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            ST_SCROLL:
            begin
                // Copy each cell one row up, writing each cell in the cycle after its read
                ram_wr_en   = pend_reg;
                ram_wr_addr = wr_addr_reg;
                ram_wr_data = cell_t'(ram_rd_data);
                if (cnt_reg < AW'(LIM))
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = cnt_reg + AW'(COLUMNS);
                    wr_addr_next = cnt_reg;
                    pend_next    = 1'b1;
                    cnt_next     = cnt_reg + AW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = AW'(LIM);
                    state_next = ST_FILL;
                end
            end

            ST_COLOR:
            begin
                // Apply one color parameter per cycle
                if (p >= SGR_FG_LO && p <= SGR_FG_HI)
                begin
                    fg_next = 3'(p - SGR_FG_LO);
                end
                else if (p >= SGR_BG_LO && p <= SGR_BG_HI)
                begin
                    bg_next = 3'(p - SGR_BG_LO);
                end
                else if (p == SGR_FG_DEF)
                begin
                    fg_next = COLOR_WHITE;
                end
                else if (p == SGR_BG_DEF)
                begin
                    bg_next = COLOR_BLACK;
                end
                if (j_reg == slot_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end

            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = (is_read_reg && in_range_reg) ?
                                     cell_t'(ram_rd_data) : '0;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    is_read_next = func;
                    state_next   = ST_FINISH;
                    if (func)
                    begin
                        // Read one cell
                        ram_rd_en     = 1'b1;
                        in_range_next = XW'(cell_addr) < XW'(CELLS);
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_ESC:
                            begin
                                mode_next = MODE_NORMAL;
                                if (data_byte == CH_SAVE)
                                begin
                                    srow_next = row_reg;
                                    scol_next = col_reg;
                                end
                                else if (data_byte == CH_REST)
                                begin
                                    row_next = srow_reg;
                                    col_next = scol_reg;
                                end
                                else if (data_byte == CH_LBRACK)
                                begin
                                    for (int i = 0; i < PARAM_SLOTS; i++)
                                    begin
                                        nums_next[i] = 8'd0;
                                    end
                                    acc_next  = 8'd0;
                                    slot_next = '0;
                                    mode_next = MODE_CSI;
                                end
                            end

                            MODE_CSI:
                            begin
                                if (data_byte >= CH_DIG0 && data_byte <= CH_DIG9)
                                begin
                                    // Accumulate a decimal digit, saturating
                                    acc_next = (dig_sum > 12'(NUM_MAX)) ?
                                               NUM_MAX : dig_sum[7:0];
                                    nums_next[slot_reg] = acc_next;
                                end
                                else if (data_byte == CH_SEMI)
                                begin
                                    if (slot_reg != SW'(PARAM_SLOTS - 1))
                                    begin
                                        slot_next = slot_reg + SW'(1);
                                        acc_next  = 8'd0;
                                    end
                                end
                                else
                                begin
                                    mode_next = MODE_NORMAL;
                                    if (data_byte == CH_SGR)
                                    begin
                                        j_next     = '0;
                                        state_next = ST_COLOR;
                                    end
                                    else if (data_byte == CH_CUB)
                                    begin
                                        col_next = (n0 >= 8'(col_reg)) ? '0 :
                                                   CLW'(8'(col_reg) - n0);
                                    end
                                    else if (data_byte == CH_CUF)
                                    begin
                                        col_next = (col_sum >= 9'(COLUMNS)) ?
                                                   CLW'(COLUMNS - 1) : CLW'(col_sum);
                                    end
                                    else if (data_byte == CH_CUP || data_byte == CH_HVP)
                                    begin
                                        row_next = (9'(nums_reg[0]) >= 9'(ROWS)) ?
                                                   RW'(ROWS - 1) : RW'(nums_reg[0]);
                                        col_next = (9'(nums_reg[1]) >= 9'(COLUMNS)) ?
                                                   CLW'(COLUMNS - 1) : CLW'(nums_reg[1]);
                                    end
                                    else if (data_byte == CH_ED && nums_reg[0] == ED_ALL)
                                    begin
                                        row_next   = '0;
                                        col_next   = '0;
                                        cnt_next   = '0;
                                        state_next = ST_FILL;
                                    end
                                end
                            end

                            MODE_NORMAL:
                            begin
                                if (data_byte == CH_ESC)
                                begin
                                    mode_next = MODE_ESC;
                                end
                                else if (data_byte == CH_DEL)
                                begin
                                    // Step back and blank that cell
                                    if (back_ok)
                                    begin
                                        row_next    = back_row;
                                        col_next    = back_col;
                                        ram_wr_en   = 1'b1;
                                        ram_wr_data = blank;
                                    end
                                end
                                else if (data_byte == CH_BS)
                                begin
                                    row_next = back_row;
                                    col_next = back_col;
                                end
                                else if (data_byte == CH_CR)
                                begin
                                    col_next = '0;
                                end
                                else if (data_byte == CH_LF)
                                begin
                                    if (row_reg == RW'(ROWS - 1))
                                    begin
                                        cnt_next   = '0;
                                        pend_next  = 1'b0;
                                        state_next = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + RW'(1);
                                    end
                                end
                                else if (data_byte >= CH_SPACE && data_byte <= CH_TILDE)
                                begin
                                    // Print at the cursor and advance
                                    ram_wr_en = 1'b1;
                                    if (col_reg == CLW'(COLUMNS - 1))
                                    begin
                                        col_next = '0;
                                        if (row_reg == RW'(ROWS - 1))
                                        begin
                                            cnt_next   = '0;
                                            pend_next  = 1'b0;
                                            state_next = ST_SCROLL;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + RW'(1);
                                        end
                                    end
                                    else
                                    begin
                                        col_next = col_reg + CLW'(1);
                                    end
                                end
                            end

                            default:
                            begin
                                mode_next = MODE_NORMAL;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            mode_reg      <= MODE_NORMAL;
            row_reg       <= '0;
            col_reg       <= '0;
            srow_reg      <= '0;
            scol_reg      <= '0;
            fg_reg        <= COLOR_WHITE;
            bg_reg        <= COLOR_BLACK;
            slot_reg      <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            is_read_reg   <= 1'b0;
            in_range_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            slot_reg      <= slot_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            is_read_reg   <= is_read_next;
            in_range_reg  <= in_range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        nums_reg     <= nums_next;
        wr_addr_reg  <= wr_addr_next;
        out_cell_reg <= out_cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = out_cell_reg.ch;
    assign cell_fg    = out_cell_reg.fg;
    assign cell_bg    = out_cell_reg.bg;
    assign pos_row    = 5'(out_row_reg);
    assign pos_col    = 7'(out_col_reg);

endmodule

`default_nettype wire

// ===== hdl/atx_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module atx_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
